/* rtl/core/gect_pkg.sv */
package gect_pkg;

	// default sizes
	localparam int DEF_TRACKS      = 5;
	localparam int DEF_SAMPLE_BITS = 10;
	localparam int DEF_COUNT_BITS  = 16;

	// fixed item layout
	localparam int SAMPLE_FIELDS = 5;
	localparam int MAX_TRACKS    = 12;
	localparam int WRAP_BITS     = 5;
	localparam int CFG_IDX_BITS  = 2;

	// register reset values
	localparam int HIGH_THR_RST  = 400;
	localparam int LOW_THR_RST   = 300;
	localparam int START_THR_RST = 450;
	localparam int WRAP_THR_RST  = 20;

	typedef enum logic {
		OP_START  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_HIGH_THR  = 2'd0,
		REG_LOW_THR   = 2'd1,
		REG_START_THR = 2'd2,
		REG_WRAP_THR  = 2'd3
	} cfg_reg_t;

	// gray to binary, running xor from the top bit down
	function automatic logic [MAX_TRACKS-1:0] gray_to_bin(input logic [MAX_TRACKS-1:0] g);
		logic [MAX_TRACKS-1:0] b;
		logic                  acc;
		acc = 1'b0;
		b   = '0;
		for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
			acc  = acc ^ g[i];
			b[i] = acc;
		end
		return b;
	endfunction

endpackage

/* rtl/core/gray_encoder_change_tracker.sv */
// gray-code disc tracker: one item carries an opcode and one adc sample per track
// input channel in_valid/in_ready with opcode and sample_0..sample_4;
// result channel out_valid/out_ready with change_count, changed, direction,
// start_position and now_position
// a start item latches the levels from start_threshold as the initial code and
// clears the change count; a sample item applies high/low hysteresis per track
// configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); indexes:
// high, low, start, wrap threshold; it is to be written by the user while no item
// is in flight, which the block does not enforce; an accepted item goes to the
// input register, then through the level/decode logic into the result register
// throughput: one item per cycle while out_ready is high (single result register)
// reset clears track levels, start code and counter, and loads the default
// thresholds; no items are held
// when out_ready is low the result holds, the input register still takes one
// more item, and in_ready drops once both registers are full
module gray_encoder_change_tracker #(
	parameter int TRACKS      = gect_pkg::DEF_TRACKS,
	parameter int SAMPLE_BITS = gect_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = gect_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gect_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]            cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [SAMPLE_BITS-1:0]            sample_0,
	input  logic [SAMPLE_BITS-1:0]            sample_1,
	input  logic [SAMPLE_BITS-1:0]            sample_2,
	input  logic [SAMPLE_BITS-1:0]            sample_3,
	input  logic [SAMPLE_BITS-1:0]            sample_4,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS-1:0]             change_count,
	output logic                              changed,
	output logic                              direction,
	output logic [TRACKS-1:0]                 start_position,
	output logic [TRACKS-1:0]                 now_position
);
	import gect_pkg::*;

	logic [SAMPLE_BITS-1:0]                    high_thr;
	logic [SAMPLE_BITS-1:0]                    low_thr;
	logic [SAMPLE_BITS-1:0]                    start_thr;
	logic [WRAP_BITS-1:0]                      wrap_thr;
	logic                                      valid_s1;
	opcode_t                                   op_s1;
	logic [SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samp_s1;
	logic                                      take;

	gect_cfg #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.high_thr  (high_thr),
		.low_thr   (low_thr),
		.start_thr (start_thr),
		.wrap_thr  (wrap_thr)
	);

	gect_in_stage #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sample_0 (sample_0),
		.sample_1 (sample_1),
		.sample_2 (sample_2),
		.sample_3 (sample_3),
		.sample_4 (sample_4),
		.take     (take),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.samp_s1  (samp_s1)
	);

	gect_core #(
		.TRACKS      (TRACKS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.op_s1          (op_s1),
		.samp_s1        (samp_s1),
		.take           (take),
		.high_thr       (high_thr),
		.low_thr        (low_thr),
		.start_thr      (start_thr),
		.wrap_thr       (wrap_thr),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.change_count   (change_count),
		.changed        (changed),
		.direction      (direction),
		.start_position (start_position),
		.now_position   (now_position)
	);

endmodule

/* rtl/core/gect_cfg.sv */
module gect_cfg #(
	parameter int SAMPLE_BITS = gect_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gect_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]            cfg_data,
	output logic [SAMPLE_BITS-1:0]            high_thr,
	output logic [SAMPLE_BITS-1:0]            low_thr,
	output logic [SAMPLE_BITS-1:0]            start_thr,
	output logic [gect_pkg::WRAP_BITS-1:0]    wrap_thr
);
	import gect_pkg::*;

	logic [SAMPLE_BITS-1:0] high_thr_q;
	logic [SAMPLE_BITS-1:0] low_thr_q;
	logic [SAMPLE_BITS-1:0] start_thr_q;
	logic [WRAP_BITS-1:0]   wrap_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q  <= SAMPLE_BITS'(HIGH_THR_RST);
			low_thr_q   <= SAMPLE_BITS'(LOW_THR_RST);
			start_thr_q <= SAMPLE_BITS'(START_THR_RST);
			wrap_thr_q  <= WRAP_BITS'(WRAP_THR_RST);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_HIGH_THR:  high_thr_q  <= cfg_data;
				REG_LOW_THR:   low_thr_q   <= cfg_data;
				REG_START_THR: start_thr_q <= cfg_data;
				REG_WRAP_THR:  wrap_thr_q  <= cfg_data[WRAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign high_thr  = high_thr_q;
	assign low_thr   = low_thr_q;
	assign start_thr = start_thr_q;
	assign wrap_thr  = wrap_thr_q;

endmodule

/* rtl/core/gect_in_stage.sv */
module gect_in_stage #(
	parameter int SAMPLE_BITS = gect_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 in_valid,
	output logic                                                 in_ready,
	input  logic                                                 opcode,
	input  logic [SAMPLE_BITS-1:0]                               sample_0,
	input  logic [SAMPLE_BITS-1:0]                               sample_1,
	input  logic [SAMPLE_BITS-1:0]                               sample_2,
	input  logic [SAMPLE_BITS-1:0]                               sample_3,
	input  logic [SAMPLE_BITS-1:0]                               sample_4,
	input  logic                                                 take,
	output logic                                                 valid_s1,
	output gect_pkg::opcode_t                                    op_s1,
	output logic [gect_pkg::SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samp_s1
);
	import gect_pkg::*;

	logic                                        valid_q;
	opcode_t                                     op_q;
	logic [SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0]   samp_q;
	logic                                        load;

	// stage is free when empty or when its item moves on this cycle
	assign in_ready = !valid_q || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q      <= opcode_t'(opcode);
			samp_q[0] <= sample_0;
			samp_q[1] <= sample_1;
			samp_q[2] <= sample_2;
			samp_q[3] <= sample_3;
			samp_q[4] <= sample_4;
		end
	end

	assign valid_s1 = valid_q;
	assign op_s1    = op_q;
	assign samp_s1  = samp_q;

endmodule

/* rtl/core/gect_core.sv */
module gect_core #(
	parameter int TRACKS      = gect_pkg::DEF_TRACKS,
	parameter int SAMPLE_BITS = gect_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = gect_pkg::DEF_COUNT_BITS
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 valid_s1,
	input  gect_pkg::opcode_t                                    op_s1,
	input  logic [gect_pkg::SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samp_s1,
	output logic                                                 take,
	input  logic [SAMPLE_BITS-1:0]                               high_thr,
	input  logic [SAMPLE_BITS-1:0]                               low_thr,
	input  logic [SAMPLE_BITS-1:0]                               start_thr,
	input  logic [gect_pkg::WRAP_BITS-1:0]                       wrap_thr,
	output logic                                                 out_valid,
	input  logic                                                 out_ready,
	output logic [COUNT_BITS-1:0]                                change_count,
	output logic                                                 changed,
	output logic                                                 direction,
	output logic [TRACKS-1:0]                                    start_position,
	output logic [TRACKS-1:0]                                    now_position
);
	import gect_pkg::*;

	localparam int CMP_BITS = (TRACKS > WRAP_BITS) ? TRACKS : WRAP_BITS;

	// running state
	logic [TRACKS-1:0]     track_q;
	logic [TRACKS-1:0]     start_q;
	logic [COUNT_BITS-1:0] count_q;

	// result register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] count_res_q;
	logic                  changed_q;
	logic                  dir_q;
	logic [TRACKS-1:0]     spos_q;
	logic [TRACKS-1:0]     npos_q;

	logic [TRACKS-1:0]     start_lv;
	logic [TRACKS-1:0]     hyst_lv;
	logic                  is_sample;
	logic [TRACKS-1:0]     track_nx;
	logic [TRACKS-1:0]     start_nx;
	logic [COUNT_BITS-1:0] count_nx;
	logic                  changed_nx;
	logic [TRACKS-1:0]     spos_nx;
	logic [TRACKS-1:0]     npos_nx;
	logic                  neg;
	logic [TRACKS-1:0]     mag;
	logic                  wrapped;
	logic                  dir_nx;

	genvar t;
	generate
		for (t = 0; t < TRACKS; t++) begin : g_track
			logic [SAMPLE_BITS-1:0] s;
			// tracks past the sample fields read zero
			if (t < SAMPLE_FIELDS) begin : g_has
				assign s = samp_s1[t];
			end else begin : g_none
				assign s = '0;
			end
			assign start_lv[t] = (s > start_thr);
			assign hyst_lv[t]  = (s > high_thr) ? 1'b1 :
			                     (s < low_thr)  ? 1'b0 : track_q[t];
		end
	endgenerate

	always_comb begin
		is_sample  = (op_s1 == OP_SAMPLE);
		changed_nx = is_sample && (hyst_lv != track_q);
		track_nx   = is_sample ? hyst_lv : start_lv;
		start_nx   = is_sample ? start_q : start_lv;
		if (!is_sample) begin
			count_nx = '0;
		end else if (changed_nx && (count_q != {COUNT_BITS{1'b1}})) begin
			count_nx = count_q + COUNT_BITS'(1);
		end else begin
			count_nx = count_q;
		end
		spos_nx = TRACKS'(gray_to_bin(MAX_TRACKS'(start_nx)));
		npos_nx = TRACKS'(gray_to_bin(MAX_TRACKS'(track_nx)));
		neg     = (spos_nx < npos_nx);
		mag     = neg ? (npos_nx - spos_nx) : (spos_nx - npos_nx);
		wrapped = (CMP_BITS'(mag) > CMP_BITS'(wrap_thr));
		// past the wrap gap the sense of the difference flips
		dir_nx  = wrapped ? neg : !neg;
	end

	assign take = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			track_q     <= '0;
			start_q     <= '0;
			count_q     <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				track_q     <= track_nx;
				start_q     <= start_nx;
				count_q     <= count_nx;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_res_q <= count_nx;
			changed_q   <= changed_nx;
			dir_q       <= dir_nx;
			spos_q      <= spos_nx;
			npos_q      <= npos_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign change_count   = count_res_q;
	assign changed        = changed_q;
	assign direction      = dir_q;
	assign start_position = spos_q;
	assign now_position   = npos_q;

endmodule

/* tb/tb_gray_encoder_change_tracker.sv */
`timescale 1ns / 100ps

module tb_gray_encoder_change_tracker;
	import gect_pkg::*;

	localparam int TRK          = DEF_TRACKS;
	localparam int SBITS        = DEF_SAMPLE_BITS;
	localparam int CBITS        = DEF_COUNT_BITS;
	localparam int SMAX         = (1 << SBITS) - 1;
	localparam int HOLD_CYCLES  = 250;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TOGGLE_ITEMS = 8;
	localparam int MAX_REPORTS  = 30;

	typedef logic [SBITS-1:0] sample_t;
	typedef logic [TRK-1:0][SBITS-1:0] sample_set_t;

	typedef struct packed {
		opcode_t     op;
		sample_set_t smp;
	} disc_item_t;

	typedef struct packed {
		logic [CBITS-1:0] count;
		logic             chg;
		logic             dir;
		logic [TRK-1:0]   spos;
		logic [TRK-1:0]   npos;
	} disc_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_wr_en = 1'b0;
	cfg_reg_t            cfg_index = REG_HIGH_THR;
	sample_t             cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	opcode_t             opcode    = OP_START;
	sample_t             sample_0  = '0;
	sample_t             sample_1  = '0;
	sample_t             sample_2  = '0;
	sample_t             sample_3  = '0;
	sample_t             sample_4  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CBITS-1:0]    change_count;
	logic                changed;
	logic                direction;
	logic [TRK-1:0]      start_position;
	logic [TRK-1:0]      now_position;

	// predictor copy of the block state and thresholds
	logic [TRK-1:0]       lvl_now   = '0;
	logic [TRK-1:0]       lvl_start = '0;
	logic [CBITS-1:0]     chg_total = '0;
	sample_t              thr_hi    = sample_t'(HIGH_THR_RST);
	sample_t              thr_lo    = sample_t'(LOW_THR_RST);
	sample_t              thr_start = sample_t'(START_THR_RST);
	logic [WRAP_BITS-1:0] thr_wrap  = WRAP_BITS'(WRAP_THR_RST);

	disc_item_t   pending_items[$];
	disc_result_t expected_results[$];
	disc_item_t   offer;

	int items_in     = 0;
	int starts_seen  = 0;
	int changes_seen = 0;
	int results_seen = 0;
	int errors       = 0;
	int cycles       = 0;
	int idle_pct     = 19;
	int hold_req     = 0;
	int hold_ack     = 0;
	int hold_left    = 0;

	gray_encoder_change_tracker DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.sample_0       (sample_0),
		.sample_1       (sample_1),
		.sample_2       (sample_2),
		.sample_3       (sample_3),
		.sample_4       (sample_4),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.change_count   (change_count),
		.changed        (changed),
		.direction      (direction),
		.start_position (start_position),
		.now_position   (now_position)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [TRK-1:0] gray_of(int p);
		return TRK'(p ^ (p >> 1));
	endfunction

	function automatic int gray_decode(logic [TRK-1:0] g);
		logic [TRK-1:0] b;
		b[TRK-1] = g[TRK-1];
		for (int i = TRK - 2; i >= 0; i--)
			b[i] = b[i+1] ^ g[i];
		return int'(b);
	endfunction

	function automatic disc_result_t track_step(disc_item_t it);
		logic [TRK-1:0] nxt;
		int             spos;
		int             npos;
		int             gap;
		int             mag;
		disc_result_t   r;
		r.chg = 1'b0;
		if (it.op == OP_START) begin
			for (int t = 0; t < TRK; t++)
				nxt[t] = it.smp[t] > thr_start;
			lvl_now   = nxt;
			lvl_start = nxt;
			chg_total = '0;
			starts_seen++;
		end else begin
			nxt = lvl_now;
			// high test wins when the thresholds are inverted
			for (int t = 0; t < TRK; t++) begin
				if (it.smp[t] > thr_hi)
					nxt[t] = 1'b1;
				else if (it.smp[t] < thr_lo)
					nxt[t] = 1'b0;
			end
			if (nxt != lvl_now) begin
				r.chg   = 1'b1;
				lvl_now = nxt;
				changes_seen++;
				if (chg_total != '1)
					chg_total = chg_total + CBITS'(1);
			end
		end
		spos = gray_decode(lvl_start);
		npos = gray_decode(lvl_now);
		gap  = spos - npos;
		mag  = gap < 0 ? -gap : gap;
		if (mag > int'(thr_wrap))
			r.dir = gap < 0;
		else
			r.dir = !(gap < 0);
		r.count = chg_total;
		r.spos  = TRK'(spos);
		r.npos  = TRK'(npos);
		return r;
	endfunction

	function automatic sample_t above(sample_t t);
		return t == SMAX ? sample_t'(SMAX) : sample_t'($urandom_range(SMAX, t + 1));
	endfunction

	// clean track levels for a code, now and then a sample inside the hysteresis band
	function automatic sample_set_t track_samples(logic [TRK-1:0] code, bit at_start);
		sample_set_t s;
		for (int t = 0; t < TRK; t++) begin
			if (at_start)
				s[t] = code[t] ? above(thr_start) : sample_t'($urandom_range(thr_start, 0));
			else if (thr_lo <= thr_hi && $urandom_range(4) == 0)
				s[t] = sample_t'($urandom_range(thr_hi, thr_lo));
			else if (code[t])
				s[t] = above(thr_hi);
			else
				s[t] = thr_lo == 0 ? sample_t'(0) : sample_t'($urandom_range(thr_lo - 1, 0));
		end
		return s;
	endfunction

	function automatic sample_set_t solid(logic [TRK-1:0] code);
		sample_set_t s;
		for (int t = 0; t < TRK; t++)
			s[t] = code[t] ? sample_t'(SMAX) : sample_t'(0);
		return s;
	endfunction

	function automatic sample_set_t mk5(int a, int b, int c, int d, int e);
		sample_set_t s;
		s[0] = sample_t'(a);
		s[1] = sample_t'(b);
		s[2] = sample_t'(c);
		s[3] = sample_t'(d);
		s[4] = sample_t'(e);
		return s;
	endfunction

	function automatic sample_t noise_sample();
		case ($urandom_range(7))
			0: return sample_t'(0);
			1: return sample_t'(SMAX);
			2: return thr_hi;
			3: return above(thr_hi);
			4: return thr_lo;
			5: return thr_lo == 0 ? sample_t'(0) : sample_t'(thr_lo - 1);
			6: return sample_t'($urandom_range(thr_start + 1, thr_start == 0 ? 0 : thr_start - 1));
			default: return sample_t'($urandom_range(SMAX));
		endcase
	endfunction

	function automatic void push_item(opcode_t op, sample_set_t s);
		disc_item_t it;
		it.op  = op;
		it.smp = s;
		pending_items.push_back(it);
	endfunction

	// start somewhere on the disc, then mostly single steps either way
	function automatic void queue_walk(int len);
		int pos;
		int r;
		pos = $urandom_range(31);
		push_item(OP_START, track_samples(gray_of(pos), 1'b1));
		repeat (len) begin
			r = $urandom_range(9);
			if (r < 6)
				pos = (pos + 1) % 32;
			else if (r < 8)
				pos = (pos + 31) % 32;
			else if (r == 8)
				pos = $urandom_range(31);
			push_item(OP_SAMPLE, track_samples(gray_of(pos), 1'b0));
		end
	endfunction

	function automatic void queue_noise();
		sample_set_t s;
		for (int t = 0; t < TRK; t++)
			s[t] = noise_sample();
		push_item($urandom_range(3) == 0 ? OP_START : OP_SAMPLE, s);
	endfunction

	function automatic void run_random(int n);
		int queued;
		int len;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(9) < 7) begin
				len = $urandom_range(15, 4);
				queue_walk(len);
				queued += len + 1;
			end else begin
				queue_noise();
				queued++;
			end
		end
	endfunction

	task automatic write_reg(cfg_reg_t idx, sample_t v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_HIGH_THR:  thr_hi    = v;
			REG_LOW_THR:   thr_lo    = v;
			REG_START_THR: thr_start = v;
			REG_WRAP_THR:  thr_wrap  = v[WRAP_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(int hi, int lo, int st, int wrap_raw);
		write_reg(REG_HIGH_THR, sample_t'(hi));
		write_reg(REG_LOW_THR, sample_t'(lo));
		write_reg(REG_START_THR, sample_t'(st));
		write_reg(REG_WRAP_THR, sample_t'(wrap_raw));
	endtask

	// look at the falling edge so the sender's updates have settled
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// sender: holds an item until it is taken, idles at random between items
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(track_step(offer));
				items_in++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					offer = pending_items.pop_front();
					opcode   <= offer.op;
					sample_0 <= offer.smp[0];
					sample_1 <= offer.smp[1];
					sample_2 <= offer.smp[2];
					sample_3 <= offer.smp[3];
					sample_4 <= offer.smp[4];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result, random stalls plus one long hold-off on request
	always @(posedge clk) begin : result_check
		disc_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got count %0d now %0d",
							$time, change_count, now_position);
				end else begin
					want = expected_results.pop_front();
					check_field("change_count", int'(want.count), int'(change_count));
					check_field("changed", int'(want.chg), int'(changed));
					check_field("direction", int'(want.dir), int'(direction));
					check_field("start_position", int'(want.spos), int'(start_position));
					check_field("now_position", int'(want.npos), int'(now_position));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_req != hold_ack) begin
				hold_ack  <= hold_req;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("tb_gray_encoder_change_tracker NOT OK");
			$finish;
		end
	end

	initial begin
		int hi;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: hysteresis edges, start edges, direction and wrap limits
		push_item(OP_SAMPLE, solid('0));
		push_item(OP_SAMPLE, solid('1));
		push_item(OP_START, mk5(450, 451, 450, 451, 450));
		push_item(OP_SAMPLE, mk5(400, 401, 300, 299, 350));
		push_item(OP_SAMPLE, mk5(350, 350, 350, 350, 350));
		push_item(OP_START, solid(gray_of(0)));
		push_item(OP_SAMPLE, solid(gray_of(31)));
		push_item(OP_SAMPLE, solid(gray_of(1)));
		push_item(OP_SAMPLE, solid(gray_of(20)));
		push_item(OP_SAMPLE, solid(gray_of(21)));
		push_item(OP_SAMPLE, solid(gray_of(0)));
		push_item(OP_START, solid(gray_of(31)));
		push_item(OP_SAMPLE, solid(gray_of(0)));
		push_item(OP_SAMPLE, solid(gray_of(30)));
		push_item(OP_SAMPLE, solid(gray_of(30)));
		push_item(OP_START, solid('1));
		push_item(OP_SAMPLE, mk5(0, 1023, 0, 1023, 0));
		push_item(OP_START, solid('0));
		push_item(OP_SAMPLE, mk5(1023, 401, 399, 301, 1023));
		wait_idle();

		// long receiver hold-off while the sender keeps offering
		run_random(100);
		@(posedge clk);
		hold_req <= hold_req + 1;
		wait_idle();

		// extreme thresholds, with a stretch of no idling on either side
		idle_pct <= 0;
		apply_cfg(SMAX, 0, 0, 0);
		run_random(60);
		wait_idle();
		idle_pct <= 19;

		// inverted thresholds, wrap written with junk above its five bits
		apply_cfg(0, SMAX, SMAX, SMAX);
		run_random(60);
		wait_idle();

		repeat (4) begin
			hi = $urandom_range(SMAX);
			apply_cfg(hi, $urandom_range(hi, 0), $urandom_range(SMAX), $urandom_range(SMAX));
			run_random(60);
			wait_idle();
		end

		// back to defaults: a run of toggles, then a start clears the count
		apply_cfg(HIGH_THR_RST, LOW_THR_RST, START_THR_RST, WRAP_THR_RST);
		push_item(OP_START, solid('0));
		for (int i = 0; i < TOGGLE_ITEMS; i++)
			push_item(OP_SAMPLE, solid(i % 2 == 0 ? gray_of(1) : gray_of(0)));
		push_item(OP_START, solid(gray_of(7)));
		push_item(OP_SAMPLE, solid(gray_of(8)));
		wait_idle();
		repeat (20) @(posedge clk);

		$display("%0d items (%0d start items) driven, %0d results checked, %0d level changes",
			items_in, starts_seen, results_seen, changes_seen);
		$display("eight threshold settings incl. extremes and inversion, one long output stall");
		if (errors == 0)
			$display("tb_gray_encoder_change_tracker OK");
		else
			$display("tb_gray_encoder_change_tracker NOT OK");
		$finish;
	end

endmodule

/* gray_encoder_change_tracker.f */
rtl/core/gect_pkg.sv
rtl/core/gect_cfg.sv
rtl/core/gect_in_stage.sv
rtl/core/gect_core.sv
rtl/core/gray_encoder_change_tracker.sv
tb/tb_gray_encoder_change_tracker.sv
